// File: src/sem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Types and constants shared by the Sobel edge magnitude stream.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int FW_W           = 11;
    localparam int FH_W           = 16;
    localparam int CMP_W          = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;
    localparam int ROW_W          = 16;
    localparam int LUMA_W         = 18;
    localparam int ALPHA_W        = 8;
    localparam int ENTRY_W        = LUMA_W + ALPHA_W;
    localparam int GRAD_W         = 22;
    localparam int SQ_W           = 44;
    localparam int ROOT_W         = SQ_W / 2;
    localparam int SQRT_STEPS     = SQ_W / 2;
    localparam int STEP_W         = $clog2(SQRT_STEPS);
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // Squared gradient at or above 254500^2 rounds to 255 or more.
    localparam logic [SQ_W-1:0] SAT_LIMIT = 44'd64770250000;
    localparam logic [7:0]      EDGE_MAX  = 8'd255;

    // Division by 1000 through a reciprocal slightly below 1/1000.
    localparam int              RECIP_SHIFT = 20;
    localparam logic [10:0]     RECIP_MULT  = 11'd1048;
    localparam logic [9:0]      DIVISOR     = 10'd1000;
    localparam logic [9:0]      ROUND_HALF  = 10'd500;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [9:0]  out_col;
        logic [15:0] out_row;
        logic [7:0]  edge_value;
        logic [7:0]  out_alpha;
        logic        last_of_run;
    } edge_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: src/sobel_edge_magnitude_stream.sv
// A word is accepted only while the block is idle; it then occupies the block until
// each of its results has been computed and taken, so any output stall holds the input.
// Each result goes through the single iterative square root unless saturated; a word
// with no result passes only through the read and pick states. A word causes up to four results.
// Reset (synchronous, active low) clears counters, window, result mask and output valid
// and loads the default frame size; the line stores and datapath registers are not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream
// Streaming 3x3 Sobel gradient magnitude over RGBA pixels with two line stores.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream
    import sem_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output edge_t                 m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_PICK, ST_GRAD, ST_SQUARE,
        ST_ROOT, ST_WAIT, ST_DIV, ST_FIX, ST_OUT
    } state_t;

    state_t state_reg;

    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [COL_W-1:0] col_reg, x_reg;
    logic [ROW_W-1:0] row_reg, y_reg;
    logic [LUMA_W-1:0]  luma_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [2:0][LUMA_W-1:0] win0_reg, win1_reg, win2_reg;
    logic [ALPHA_W-1:0] wa0_reg, wa1_reg;
    logic [3:0][ALPHA_W-1:0] job_alpha_reg;
    logic [3:0] mask_reg;
    logic [1:0] job_reg;
    logic       last_reg;
    logic signed [GRAD_W-1:0] sx_reg, sy_reg;
    logic [SQ_W-1:0] sq_reg;
    logic [LUMA_W-1:0] v_reg;
    logic [8:0]  q0_reg;
    logic        m_valid_reg;
    edge_t       m_data_reg;

    logic [ENTRY_W-1:0] old_e, new_e;
    logic [LUMA_W-1:0]  luma_in;
    logic [CMP_W-1:0]   w_eff, x_ext;
    logic               last_col, last_row;
    sqrt_req_t          sq_req;
    sqrt_rsp_t          sq_rsp;

    logic [1:0] top_i, mid_i, lft_i, ctr_i;
    logic [2:0][LUMA_W-1:0] rt, rm, rb;
    logic signed [GRAD_W-1:0] sx_c, sy_c;
    logic [3:0] mask_left;
    logic [1:0] next_job;
    logic [28:0] prod_q;
    logic [18:0] prod_back;
    logic [8:0]  q_fix;
    logic [2*GRAD_W-1:0] sqx, sqy;

    function automatic logic [LUMA_W-1:0] pick_col(input logic [2:0][LUMA_W-1:0] r,
                                                   input logic [1:0] c);
        logic [LUMA_W-1:0] v;
        unique case (c)
            2'd0:    v = r[0];
            2'd1:    v = r[1];
            default: v = r[2];
        endcase
        return v;
    endfunction

    function automatic logic [2:0][LUMA_W-1:0] pick_row(input logic [1:0] i,
            input logic [2:0][LUMA_W-1:0] a, input logic [2:0][LUMA_W-1:0] b,
            input logic [2:0][LUMA_W-1:0] c);
        logic [2:0][LUMA_W-1:0] v;
        unique case (i)
            2'd0:    v = a;
            2'd1:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

    function automatic logic signed [GRAD_W-1:0] ext(input logic [LUMA_W-1:0] l);
        return $signed({{(GRAD_W-LUMA_W){1'b0}}, l});
    endfunction

    assign luma_in = LUMA_W'(s_data.red) * 18'd299 + LUMA_W'(s_data.green) * 18'd587
                   + LUMA_W'(s_data.blue) * 18'd114;

    // Effective frame size: zero reads as one, width saturates at the line size.
    always_comb begin
        if (fw_reg == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(fw_reg) > CMP_W'(MAX_LINE_WIDTH)) begin
            w_eff = CMP_W'(MAX_LINE_WIDTH);
        end else begin
            w_eff = CMP_W'(fw_reg);
        end
    end
    assign x_ext    = CMP_W'(x_reg);
    assign last_col = x_ext >= w_eff - 1'b1;
    assign last_row = (fh_reg == '0) ? 1'b1 : (y_reg >= fh_reg - 1'b1);

    sem_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LINE_WIDTH)) u_older (
        .aclk(aclk), .we(state_reg == ST_READ), .waddr(x_reg), .wdata(new_e),
        .re(s_valid && s_ready), .raddr(col_reg), .rdata(old_e)
    );

    sem_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LINE_WIDTH)) u_newer (
        .aclk(aclk), .we(state_reg == ST_READ), .waddr(x_reg),
        .wdata({alpha_reg, luma_reg}),
        .re(s_valid && s_ready), .raddr(col_reg), .rdata(new_e)
    );

    // Row and column taps for the current job, with clamping at the borders.
    always_comb begin
        if (!job_reg[1]) begin
            top_i = (y_reg == ROW_W'(1)) ? 2'd1 : 2'd0;
            mid_i = 2'd1;
        end else begin
            top_i = (y_reg == '0) ? 2'd2 : 2'd1;
            mid_i = 2'd2;
        end
        if (!job_reg[0]) begin
            lft_i = (x_reg == COL_W'(1)) ? 2'd1 : 2'd0;
            ctr_i = 2'd1;
        end else begin
            lft_i = (x_reg == '0) ? 2'd2 : 2'd1;
            ctr_i = 2'd2;
        end
        rt = pick_row(top_i, win0_reg, win1_reg, win2_reg);
        rm = pick_row(mid_i, win0_reg, win1_reg, win2_reg);
        rb = win2_reg;
        sx_c = (ext(rt[2]) - ext(pick_col(rt, lft_i)))
             + ((ext(rm[2]) - ext(pick_col(rm, lft_i))) <<< 1)
             + (ext(rb[2]) - ext(pick_col(rb, lft_i)));
        sy_c = (ext(pick_col(rb, lft_i)) - ext(pick_col(rt, lft_i)))
             + ((ext(pick_col(rb, ctr_i)) - ext(pick_col(rt, ctr_i))) <<< 1)
             + (ext(rb[2]) - ext(rt[2]));
    end

    assign sqx = sx_reg * sx_reg;
    assign sqy = sy_reg * sy_reg;

    // Next pending result, in row-then-column order.
    always_comb begin
        priority if (mask_reg[0]) begin
            next_job = 2'd0;
        end else if (mask_reg[1]) begin
            next_job = 2'd1;
        end else if (mask_reg[2]) begin
            next_job = 2'd2;
        end else begin
            next_job = 2'd3;
        end
        mask_left = mask_reg & ~(4'b0001 << next_job);
    end

    assign prod_q    = 29'(v_reg) * 29'(RECIP_MULT);
    assign prod_back = 19'(q0_reg) * 19'(DIVISOR);
    assign q_fix     = ((19'(v_reg) - prod_back) >= 19'(DIVISOR)) ? q0_reg + 1'b1 : q0_reg;

    assign sq_req.start = (state_reg == ST_ROOT) && (sq_reg < SAT_LIMIT);
    assign sq_req.value = sq_reg;

    sem_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .req(sq_req), .rsp(sq_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fw_reg      <= FRAME_WIDTH_RESET;
            fh_reg      <= FRAME_HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            win0_reg    <= '0;
            win1_reg    <= '0;
            win2_reg    <= '0;
            wa0_reg     <= '0;
            wa1_reg     <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    fw_reg <= cfg_data[FW_W-1:0];
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    fh_reg <= cfg_data[FH_W-1:0];
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        luma_reg  <= luma_in;
                        alpha_reg <= s_data.alpha;
                        x_reg     <= col_reg;
                        y_reg     <= row_reg;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    win0_reg <= {old_e[LUMA_W-1:0], win0_reg[2], win0_reg[1]};
                    win1_reg <= {new_e[LUMA_W-1:0], win1_reg[2], win1_reg[1]};
                    win2_reg <= {luma_reg, win2_reg[2], win2_reg[1]};
                    job_alpha_reg <= {alpha_reg, wa1_reg, new_e[ENTRY_W-1:LUMA_W], wa0_reg};
                    wa0_reg  <= new_e[ENTRY_W-1:LUMA_W];
                    wa1_reg  <= alpha_reg;
                    mask_reg <= {last_row && last_col, last_row && (x_reg != '0),
                                 (y_reg != '0) && last_col,
                                 (y_reg != '0) && (x_reg != '0)};
                    if (last_col) begin
                        col_reg <= '0;
                        row_reg <= last_row ? '0 : y_reg + 1'b1;
                    end else begin
                        col_reg <= x_reg + 1'b1;
                    end
                    state_reg <= ST_PICK;
                end
                ST_PICK: begin
                    if (mask_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        job_reg   <= next_job;
                        last_reg  <= (mask_left == '0);
                        mask_reg  <= mask_left;
                        state_reg <= ST_GRAD;
                    end
                end
                ST_GRAD: begin
                    sx_reg    <= sx_c;
                    sy_reg    <= sy_c;
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    sq_reg    <= SQ_W'(sqx) + SQ_W'(sqy);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (sq_reg >= SAT_LIMIT) begin
                        m_data_reg.edge_value <= EDGE_MAX;
                        state_reg <= ST_FIX;
                        q0_reg    <= 9'(EDGE_MAX);
                        v_reg     <= LUMA_W'(EDGE_MAX) * LUMA_W'(DIVISOR);
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (sq_rsp.done) begin
                        v_reg     <= LUMA_W'(sq_rsp.root) + LUMA_W'(ROUND_HALF);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    q0_reg    <= prod_q[RECIP_SHIFT +: 9];
                    state_reg <= ST_FIX;
                end
                ST_FIX: begin
                    m_data_reg.edge_value  <= q_fix[7:0];
                    m_data_reg.out_col     <= 10'(job_reg[0] ? x_reg : x_reg - 1'b1);
                    m_data_reg.out_row     <= job_reg[1] ? y_reg : y_reg - 1'b1;
                    m_data_reg.out_alpha   <= job_alpha_reg[job_reg];
                    m_data_reg.last_of_run <= last_reg;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_PICK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a word is pending");
    a_accept_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_READ))
        else $error("line store read not followed by update");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_of_run) |=> ##1 (state_reg == ST_IDLE))
        else $error("results remain after last word of a run");
    a_root_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_rsp.done |-> (state_reg == ST_WAIT))
        else $error("square root finished outside its wait");
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT && sq_reg >= SAT_LIMIT) |=> !sq_rsp.busy)
        else $error("square root started on a saturated value");
`endif

endmodule

// File: src/sem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/sem_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sem_isqrt
    import sem_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [SQ_W-1:0]   rem_reg, res_reg, bit_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [SQ_W-1:0]   trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                rem_reg  <= req.value;
                res_reg  <= '0;
                bit_reg  <= {2'b01, {(SQ_W-2){1'b0}}};
                cnt_reg  <= STEP_W'(SQRT_STEPS - 1);
            end else if (busy_reg) begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

endmodule
